[hdl/racc_pkg.sv]
`default_nettype none

package racc_pkg;

   localparam int POS_PORT_W = 15;
   localparam int VAL_W      = 32;
   localparam int NUM_VAL    = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_SEQ_LEN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_CNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERWRITE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STRANDED  = 2'd3;

   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_SCAN   = 1'b1;

   localparam logic KIND_RUN    = 1'b0;
   localparam logic KIND_REJECT = 1'b1;

   typedef enum logic [1:0] {
      LOP_CLEAR,
      LOP_WRITE,
      LOP_ACC
   } lane_op_type;

   typedef struct packed {
      logic        rd_en;
      logic        wr_en;
      lane_op_type op;
   } lane_ctl_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD,
      ST_EVAL,
      ST_REJ
   } state_type;

   typedef struct packed {
      logic                                 kind;
      logic                                 strand;
      logic [POS_PORT_W-1:0]                start;
      logic [POS_PORT_W-1:0]                stop;
      logic [NUM_VAL-1:0][VAL_W-1:0]        val;
      logic                                 last;
   } rsp_type;

endpackage

`default_nettype wire

[hdl/range_accumulate_run_length_emit.sv]
`default_nettype none

// Two-strand positional store of saturating Q15.16 values, one lane (memory plus
// adder) per value column, with run-length scan-out. After reset a clearing pass
// writes zero to every row of the lane memories, during which no transaction is
// accepted; configuration writes are taken at any time. A range update walks the
// positions of its clipped range (read and write-back of the lane memories are
// pipelined one row a cycle), followed by one trailing write-back when
// accumulating; an update with an empty range ends at its accept. A rejected
// update and a scan item wait until the two-entry output queue is empty before
// pushing their results; a scan item after the scan has finished does nothing.
// Each scan item within the sequence length reads one row of all lanes in
// parallel and the merge stage compares it with the held run.
module range_accumulate_run_length_emit #(
   parameter int MAX_POSITIONS = 16384,
   parameter int MAX_COLUMNS   = 4
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire                req_type,
   input  wire                req_strand,
   input  wire [14:0]         req_first_pos,
   input  wire [14:0]         req_range_end,
   input  wire signed [31:0]  req_value_a,
   input  wire signed [31:0]  req_value_b,
   input  wire signed [31:0]  req_value_c,
   input  wire signed [31:0]  req_value_d,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic               rsp_kind,
   output logic               rsp_run_strand,
   output logic [14:0]        rsp_run_start,
   output logic [14:0]        rsp_run_end,
   output logic signed [31:0] rsp_run_value_a,
   output logic signed [31:0] rsp_run_value_b,
   output logic signed [31:0] rsp_run_value_c,
   output logic signed [31:0] rsp_run_value_d,
   output logic               rsp_last,
   input  wire                csr_we,
   input  wire [1:0]          csr_index,
   input  wire [14:0]         csr_wdata
);
   import racc_pkg::*;

   localparam int POS_W  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
   localparam int ADDR_W = POS_W + 1;
   localparam int LANES  = (MAX_COLUMNS < NUM_VAL) ? MAX_COLUMNS : NUM_VAL;

   // configuration
   logic [POS_PORT_W-1:0] seq_len_ff;
   logic [2:0]            col_cnt_ff;
   logic                  ovw_ff, strd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_len_ff <= 15'd16384;
         col_cnt_ff <= 3'd1;
         ovw_ff     <= 1'b0;
         strd_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SEQ_LEN:   seq_len_ff <= csr_wdata;
            CSR_COL_CNT:   col_cnt_ff <= csr_wdata[2:0];
            CSR_OVERWRITE: ovw_ff     <= csr_wdata[0];
            CSR_STRANDED:  strd_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic [POS_PORT_W-1:0] len;
   logic [3:0]            nc;
   logic [LANES-1:0]      col_en;

   always_comb begin
      if (seq_len_ff == '0) len = 15'd1;
      else if (32'(seq_len_ff) > MAX_POSITIONS) len = POS_PORT_W'(MAX_POSITIONS);
      else len = seq_len_ff;
      if (col_cnt_ff == '0) nc = 4'd1;
      else if (32'(col_cnt_ff) > MAX_COLUMNS) nc = 4'(MAX_COLUMNS);
      else nc = {1'b0, col_cnt_ff};
      for (int c = 0; c < LANES; c++) col_en[c] = (32'(c) < 32'(nc));
   end

   // control state
   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     clr_ff, clr_in;
   logic [POS_PORT_W-1:0] q_ff, q_in, hi_ff, hi_in;
   logic                  ustrand_ff, ustrand_in;
   logic                  wpend_ff, wpend_in;
   logic [ADDR_W-1:0]     waddr_ff, waddr_in;
   logic signed [31:0]    val_ff [LANES];
   logic signed [31:0]    req_val [NUM_VAL];
   logic                  beyond_ff, beyond_in;

   // scan state
   logic                  sstrand_ff, sstrand_in;
   logic [POS_PORT_W-1:0] spos_ff, spos_in;
   logic                  sdone_ff, sdone_in;
   logic [POS_PORT_W-1:0] hstart_ff, hstart_in;
   logic signed [31:0]    held_ff [LANES];
   logic signed [31:0]    held_in [LANES];

   // lane interface
   lane_ctl_type          lctl;
   logic [ADDR_W-1:0]     rd_addr, wr_addr;
   logic signed [31:0]    lane_rd [LANES];

   // output queue interface
   logic                  q_empty, push;
   logic [1:0]            push_n;
   rsp_type               push0, push1, head;

   logic                  accept;
   logic [POS_PORT_W-1:0] lo, hi;
   logic [ADDR_W-1:0]     upd_addr;
   logic signed [31:0]    dm [LANES];
   logic                  differ, held_nz, new_nz, first, load, endst, e0, e1;
   logic signed [31:0]    new_held [LANES];
   logic [POS_PORT_W-1:0] new_start;
   rsp_type               r0, r1;

   assign req_val[0] = req_value_a;
   assign req_val[1] = req_value_b;
   assign req_val[2] = req_value_c;
   assign req_val[3] = req_value_d;

   // hold off while the last accumulation is still being written back
   assign req_ready = (state_ff == ST_IDLE) && !wpend_ff;
   assign accept    = req_valid && req_ready;
   assign upd_addr  = {ustrand_ff, POS_W'(q_ff - 15'd1)};

   // merge stage: compare the row just read across all lanes with the held run;
   // columns out of use are neither compared nor reported
   always_comb begin
      differ  = 1'b0;
      held_nz = 1'b0;
      new_nz  = 1'b0;
      first   = (spos_ff == 15'd1);
      for (int c = 0; c < LANES; c++) begin
         dm[c] = col_en[c] ? lane_rd[c] : 32'sd0;
         if (col_en[c] && dm[c] != held_ff[c]) differ = 1'b1;
         if (col_en[c] && held_ff[c] != 32'sd0) held_nz = 1'b1;
      end
      load      = !beyond_ff && (first || differ);
      new_start = load ? spos_ff : hstart_ff;
      for (int c = 0; c < LANES; c++) begin
         new_held[c] = load ? dm[c] : held_ff[c];
         if (col_en[c] && new_held[c] != 32'sd0) new_nz = 1'b1;
      end
      endst = beyond_ff || (spos_ff == len);
      e0    = beyond_ff ? held_nz : (!first && differ && held_nz);
      e1    = !beyond_ff && endst && new_nz;

      r0        = '0;
      r0.kind   = KIND_RUN;
      r0.strand = sstrand_ff;
      r0.start  = hstart_ff;
      r0.stop   = spos_ff - 15'd1;
      for (int c = 0; c < LANES; c++) r0.val[c] = col_en[c] ? held_ff[c] : 32'sd0;
      r1        = '0;
      r1.kind   = KIND_RUN;
      r1.strand = sstrand_ff;
      r1.start  = new_start;
      r1.stop   = len;
      for (int c = 0; c < LANES; c++) r1.val[c] = col_en[c] ? new_held[c] : 32'sd0;
      r1.last   = 1'b1;
      r0.last   = !e1;
   end

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      q_in       = q_ff;
      hi_in      = hi_ff;
      ustrand_in = ustrand_ff;
      wpend_in   = 1'b0;
      waddr_in   = upd_addr;
      beyond_in  = beyond_ff;
      sstrand_in = sstrand_ff;
      spos_in    = spos_ff;
      sdone_in   = sdone_ff;
      hstart_in  = hstart_ff;
      for (int c = 0; c < LANES; c++) held_in[c] = held_ff[c];
      lctl       = '{rd_en: 1'b0, wr_en: 1'b0, op: LOP_WRITE};
      rd_addr    = {sstrand_ff, POS_W'(spos_ff - 15'd1)};
      wr_addr    = upd_addr;
      push       = 1'b0;
      push_n     = 2'd0;
      push0      = r0;
      push1      = r1;
      lo         = (req_first_pos == '0) ? 15'd1 : req_first_pos;
      hi         = (req_range_end > len) ? len : req_range_end;

      // write back the accumulation read in the previous cycle
      if (wpend_ff) begin
         lctl.wr_en = 1'b1;
         lctl.op    = LOP_ACC;
         wr_addr    = waddr_ff;
      end

      case (state_ff)
         ST_CLEAR: begin
            lctl.wr_en = 1'b1;
            lctl.op    = LOP_CLEAR;
            wr_addr    = clr_ff;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_UPDATE) begin
                  ustrand_in = req_strand;
                  q_in       = lo;
                  hi_in      = hi;
                  if (req_strand && !strd_ff) state_in = ST_REJ;
                  else if (lo <= hi) state_in = ST_UPD;
               end else if (!sdone_ff) begin
                  beyond_in = (spos_ff > len);
                  lctl.rd_en = (spos_ff <= len);
                  state_in  = ST_EVAL;
               end
            end
         end
         ST_UPD: begin
            if (ovw_ff) begin
               lctl.wr_en = 1'b1;
               lctl.op    = LOP_WRITE;
               wr_addr    = upd_addr;
            end else begin
               lctl.rd_en = 1'b1;
               rd_addr    = upd_addr;
               wpend_in   = 1'b1;
            end
            q_in = q_ff + 15'd1;
            if (q_ff == hi_ff) state_in = ST_IDLE;
         end
         ST_EVAL: begin
            if (q_empty) begin
               push = e0 || e1;
               push_n = 2'(e0) + 2'(e1);
               if (!e0) push0 = r1;
               if (endst) begin
                  spos_in   = 15'd1;
                  hstart_in = 15'd1;
                  for (int c = 0; c < LANES; c++) held_in[c] = 32'sd0;
                  if (sstrand_ff) begin
                     sdone_in   = 1'b1;
                     sstrand_in = 1'b0;
                  end else begin
                     sstrand_in = 1'b1;
                  end
               end else begin
                  spos_in   = spos_ff + 15'd1;
                  hstart_in = new_start;
                  for (int c = 0; c < LANES; c++) held_in[c] = new_held[c];
               end
               state_in = ST_IDLE;
            end
         end
         ST_REJ: begin
            if (q_empty) begin
               push       = 1'b1;
               push_n     = 2'd1;
               push0      = '0;
               push0.kind = KIND_REJECT;
               push0.last = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         wpend_ff   <= 1'b0;
         sstrand_ff <= 1'b0;
         spos_ff    <= 15'd1;
         sdone_ff   <= 1'b0;
         hstart_ff  <= 15'd1;
         for (int c = 0; c < LANES; c++) held_ff[c] <= 32'sd0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         wpend_ff   <= wpend_in;
         sstrand_ff <= sstrand_in;
         spos_ff    <= spos_in;
         sdone_ff   <= sdone_in;
         hstart_ff  <= hstart_in;
         for (int c = 0; c < LANES; c++) held_ff[c] <= held_in[c];
      end
      q_ff       <= q_in;
      hi_ff      <= hi_in;
      ustrand_ff <= ustrand_in;
      waddr_ff   <= waddr_in;
      beyond_ff  <= beyond_in;
      if (accept) begin
         for (int c = 0; c < LANES; c++) val_ff[c] <= req_val[c];
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      racc_lane #(.ADDR_W(ADDR_W)) u_lane (
         .clock   (clock),
         .ctl     (lctl),
         .col_en  (col_en[g]),
         .rd_addr (rd_addr),
         .wr_addr (wr_addr),
         .operand (val_ff[g]),
         .rd_data (lane_rd[g])
      );
   end

   racc_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_n    (push_n),
      .push0     (push0),
      .push1     (push1),
      .empty     (q_empty),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_kind        = head.kind;
   assign rsp_run_strand  = head.strand;
   assign rsp_run_start   = head.start;
   assign rsp_run_end     = head.stop;
   assign rsp_run_value_a = head.val[0];
   assign rsp_run_value_b = head.val[1];
   assign rsp_run_value_c = head.val[2];
   assign rsp_run_value_d = head.val[3];
   assign rsp_last        = head.last;

`ifndef NO_ASSERTIONS
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready)
      else $error("transaction accepted during clearing pass");
   a_done_strand: assert property (@(posedge clock) disable iff (reset)
      sdone_ff |-> !sstrand_ff && spos_ff == 15'd1)
      else $error("scan state not parked after completion");
   a_wb_follows_read: assert property (@(posedge clock) disable iff (reset)
      wpend_ff |-> $past(lctl.rd_en) && $past(state_ff) == ST_UPD)
      else $error("accumulate write-back without a preceding read");
   a_pos_nonzero: assert property (@(posedge clock) disable iff (reset)
      spos_ff != '0 && hstart_ff != '0)
      else $error("scan position dropped to zero");
`endif

endmodule

`default_nettype wire

[hdl/racc_lane.sv]
`default_nettype none

module racc_lane #(
   parameter int ADDR_W = 15
) (
   input  wire                          clock,
   input  wire racc_pkg::lane_ctl_type  ctl,
   input  wire                          col_en,
   input  wire [ADDR_W-1:0]             rd_addr,
   input  wire [ADDR_W-1:0]             wr_addr,
   input  wire signed [31:0]            operand,
   output logic signed [31:0]           rd_data
);
   import racc_pkg::*;

   localparam int DEPTH = 1 << ADDR_W;

   logic signed [VAL_W-1:0] mem [DEPTH];
   logic signed [VAL_W-1:0] rd_data_ff;
   logic signed [VAL_W-1:0] wr_data;
   logic        [VAL_W:0]   sum;
   logic                    wr_go;

   // saturate on signed overflow of the 33-bit sum
   always_comb begin
      sum = {rd_data_ff[VAL_W-1], rd_data_ff} + {operand[VAL_W-1], operand};
      case (ctl.op)
         LOP_CLEAR: wr_data = '0;
         LOP_WRITE: wr_data = operand;
         LOP_ACC: begin
            if (sum[VAL_W] != sum[VAL_W-1])
               wr_data = sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
            else
               wr_data = sum[VAL_W-1:0];
         end
         default: wr_data = '0;
      endcase
      wr_go = ctl.wr_en && (col_en || ctl.op == LOP_CLEAR);
   end

   always_ff @(posedge clock) begin
      if (wr_go) mem[wr_addr] <= wr_data;
      if (ctl.rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/racc_outq.sv]
`default_nettype none

module racc_outq (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  wire [1:0]               push_n,
   input  wire racc_pkg::rsp_type  push0,
   input  wire racc_pkg::rsp_type  push1,
   output logic                    empty,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output racc_pkg::rsp_type       head
);
   import racc_pkg::*;

   rsp_type    ent0_ff, ent0_in, ent1_ff, ent1_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   always_comb begin
      pop     = rsp_valid && rsp_ready;
      ent0_in = ent0_ff;
      ent1_in = ent1_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         ent0_in = push0;
         ent1_in = push1;
         cnt_in  = push_n;
      end else if (pop) begin
         ent0_in = ent1_ff;
         cnt_in  = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
      ent0_ff <= ent0_in;
      ent1_ff <= ent1_in;
   end

   assign empty     = (cnt_ff == 2'd0);
   assign rsp_valid = !empty;
   assign head      = ent0_ff;

`ifndef NO_ASSERTIONS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("output queue count out of range");
   a_push_empty: assert property (@(posedge clock) disable iff (reset) push |-> empty)
      else $error("push into non-empty output queue");
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> cnt_ff == $past(cnt_ff) - 2'd1)
      else $error("output queue lost track of a transaction");
`endif

endmodule

`default_nettype wire
